// File: rtl/core/binary_lyndon_word_engine_top_macros.svh
// ----------------------------------------------------------------------------
// binary lyndon word engine assertion macros
// implication helpers for the port checker
// ----------------------------------------------------------------------------
`ifndef BINARY_LYNDON_WORD_ENGINE_TOP_MACROS_SVH
`define BINARY_LYNDON_WORD_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define BLWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BLWE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/blwe_pkg.sv
// ----------------------------------------------------------------------------
// blwe_pkg
// shared types, mode codes and lyndon test logic of the word engine
// ----------------------------------------------------------------------------
`default_nettype none

package blwe_pkg;

  localparam int MAX_LEN = 16;
  localparam int WORD_W  = 16;
  localparam int LEN_W   = 5;
  localparam int MODE_W  = 3;
  localparam int CNT_W   = MAX_LEN + 1;

  localparam logic [MODE_W-1:0] MODE_TEST   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RANK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNRANK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREV   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TOTAL  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  length;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic              is_lyndon;
    logic              ok;
    logic [WORD_W-1:0] result_word;
    logic [WORD_W-1:0] count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } ctl_sts_t;

  function automatic logic [WORD_W-1:0] mask_of(input logic [LEN_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (LEN_W'(i) < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  // all rotations compared in parallel
  function automatic logic lyn_test(input logic [WORD_W-1:0] w,
                                    input logic [LEN_W-1:0]  n);
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] rot;
    logic              res;
    m   = mask_of(n);
    res = 1'b1;
    rot = '0;
    for (int i = 1; i < MAX_LEN; i++) begin
      if (LEN_W'(i) < n) begin
        rot = ((w << i) | (w >> (n - LEN_W'(i)))) & m;
        if (rot <= w) res = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/blwe_ctrl.sv
// ----------------------------------------------------------------------------
// blwe_ctrl
// sequencer: accept a beat, run the candidate scan, hand off the result
// ----------------------------------------------------------------------------
`default_nettype none

module blwe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire blwe_pkg::ctl_sts_t sts,
  output blwe_pkg::ctl_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/blwe_dp.sv
// ----------------------------------------------------------------------------
// blwe_dp
// datapath: request registers, candidate counter, scan accumulators and
// the output register
// ----------------------------------------------------------------------------
`default_nettype none

module blwe_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire blwe_pkg::in_item_t in_data,
  input  wire blwe_pkg::ctl_cmd_t cmd,
  output blwe_pkg::ctl_sts_t      sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output blwe_pkg::out_item_t     out_data
);

  localparam int WW = blwe_pkg::WORD_W;
  localparam int CW = blwe_pkg::CNT_W;

  logic [blwe_pkg::MODE_W-1:0] mode_r;
  logic [blwe_pkg::LEN_W-1:0]  n_r;
  logic [WW-1:0]               w_r;
  logic [WW-1:0]               idx_r;
  logic [WW-1:0]               mask_r;
  logic                        len_ok_r;
  logic                        lyn_r;

  logic [WW-1:0] cand_r;
  logic [CW-1:0] total_r;
  logic [CW-1:0] rank_r;
  logic [WW-1:0] prevw_r;
  logic [WW-1:0] nextw_r;
  logic [WW-1:0] kw_r;
  logic [WW-1:0] lastw_r;
  logic          have_next_r;
  logic          have_prev_r;
  logic          have_k_r;

  logic                out_valid_r;
  blwe_pkg::out_item_t out_r;
  blwe_pkg::out_item_t res_c;

  logic          cand_lyn;
  logic [WW-1:0] in_w;
  logic [CW-1:0] rank_eff;
  logic [CW-1:0] cnt_c;

  assign in_w     = in_data.word & blwe_pkg::mask_of(in_data.length);
  assign cand_lyn = blwe_pkg::lyn_test(cand_r, n_r);

  assign sts.scan_last = !len_ok_r || (cand_r == mask_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  // request registers and scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_data.mode;
      n_r         <= in_data.length;
      w_r         <= in_w;
      idx_r       <= in_data.index;
      mask_r      <= blwe_pkg::mask_of(in_data.length);
      len_ok_r    <= (in_data.length != '0) &&
                     (in_data.length <= blwe_pkg::LEN_W'(blwe_pkg::MAX_LEN));
      lyn_r       <= blwe_pkg::lyn_test(in_w, in_data.length);
      cand_r      <= '0;
      total_r     <= '0;
      rank_r      <= '0;
      have_next_r <= 1'b0;
      have_prev_r <= 1'b0;
      have_k_r    <= 1'b0;
    end else if (cmd.scan && len_ok_r) begin
      cand_r <= cand_r + 1'b1;
      if (cand_lyn) begin
        if (cand_r < w_r) begin
          rank_r      <= rank_r + 1'b1;
          prevw_r     <= cand_r;
          have_prev_r <= 1'b1;
        end
        if ((cand_r > w_r) && !have_next_r) begin
          nextw_r     <= cand_r;
          have_next_r <= 1'b1;
        end
        if (total_r == CW'(idx_r)) begin
          kw_r     <= cand_r;
          have_k_r <= 1'b1;
        end
        lastw_r <= cand_r;
        total_r <= total_r + 1'b1;
      end
    end
  end

  // result selection
  always_comb begin
    res_c    = '0;
    cnt_c    = '0;
    rank_eff = lyn_r ? rank_r : total_r;
    if (len_ok_r) begin
      res_c.is_lyndon = lyn_r;
      case (mode_r)
        blwe_pkg::MODE_TEST: res_c.ok = 1'b1;
        blwe_pkg::MODE_RANK: begin
          res_c.ok = 1'b1;
          cnt_c    = rank_eff;
        end
        blwe_pkg::MODE_UNRANK: begin
          if (have_k_r) begin
            res_c.ok          = 1'b1;
            res_c.result_word = kw_r;
          end
        end
        blwe_pkg::MODE_NEXT: begin
          if (lyn_r && have_next_r) begin
            res_c.ok          = 1'b1;
            res_c.result_word = nextw_r;
          end
        end
        blwe_pkg::MODE_PREV: begin
          if (!lyn_r) begin
            res_c.ok          = 1'b1;
            res_c.result_word = lastw_r;
          end else if (have_prev_r) begin
            res_c.ok          = 1'b1;
            res_c.result_word = prevw_r;
          end
        end
        blwe_pkg::MODE_TOTAL: begin
          res_c.ok = 1'b1;
          cnt_c    = total_r;
        end
        default: res_c.ok = 1'b0;
      endcase
      res_c.count = (cnt_c > CW'({WW{1'b1}})) ? {WW{1'b1}} : cnt_c[WW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= res_c;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/core/binary_lyndon_word_engine_top.sv
// ----------------------------------------------------------------------------
// binary_lyndon_word_engine_top
// lyndon word test, rank, unrank, next, prev and total count on binary words
// of length 1 to 16, by a scan over every candidate word of the length
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | blwe_pkg::in_item_t
// out     | out | out_valid/out_stall | blwe_pkg::out_item_t
//
// one beat in flight; the scan runs the candidate counter over every word of
// length n, stepping one word per cycle, then the result is registered
// a bad length ends the scan on its first step
// the next beat is taken while a result waits in the output register
// reset clears the sequencer and output valid only
// ----------------------------------------------------------------------------
`default_nettype none

module binary_lyndon_word_engine_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire blwe_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output blwe_pkg::out_item_t      out_data
);

  blwe_pkg::ctl_cmd_t cmd;
  blwe_pkg::ctl_sts_t sts;

  blwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blwe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/blwe_checker.sv
// ----------------------------------------------------------------------------
// blwe_checker
// port-level checks for the word engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_lyndon_word_engine_top_macros.svh"

module blwe_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire blwe_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire blwe_pkg::out_item_t out_data
);

  `BLWE_ASSERT_NXT(a_in_stable, in_valid && in_stall, in_valid && $stable(in_data))
  `BLWE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `BLWE_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `BLWE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BLWE_ASSERT_IMP(a_fail_clean, out_valid && !out_data.ok, ~|out_data.result_word && ~|out_data.count)

endmodule

bind binary_lyndon_word_engine_top blwe_checker u_blwe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
